FILE: rtl/utfb_pkg.sv
// ----------------------------------------------------------------------------
// UART terminated frame buffer package
// Operation and result codes, fixed field widths and the command and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package utfb_pkg;

   localparam int BYTE_W = 8;
   localparam int OP_W   = 2;
   localparam int KIND_W = 2;
   localparam int FLEN_W = 7;

   // Operation codes carried on the request tuser.
   localparam logic [OP_W-1:0] OP_TX_LOAD = 2'd0;
   localparam logic [OP_W-1:0] OP_TX_TICK = 2'd1;
   localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd2;
   localparam logic [OP_W-1:0] OP_READ    = 2'd3;

   // Result kinds carried on the response tuser.
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TX    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RX    = 2'd2;

   localparam logic [BYTE_W-1:0] END_CHAR_RESET = 8'd10;

   typedef struct packed {
      logic              tx_write;
      logic              tx_start;
      logic              tx_advance;
      logic              tx_stop;
      logic              rx_write;
      logic              rd_start;
      logic              rd_next;
      logic              mem_rd;
      logic              out_load;
      logic [KIND_W-1:0] out_kind;
   } cmd_type;

   typedef struct packed {
      logic tx_busy;
      logic tx_can_send;
      logic rx_empty;
      logic rd_is_rx;
      logic rd_last;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/utfb_ctrl.sv
// ----------------------------------------------------------------------------
// UART terminated frame buffer controller
// Decodes each request and sequences store reads and result delivery.
// ----------------------------------------------------------------------------
module utfb_ctrl
   import utfb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   input  logic            req_last,
   input  status_type      status,
   output logic            req_ready,
   output cmd_type         cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_OUT   = 2'd2;
   localparam logic [1:0] S_EMPTY = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_op)
                  OP_TX_LOAD: begin
                     if (!status.tx_busy) begin
                        cmd.tx_write = 1'b1;
                        if (req_last) begin
                           cmd.tx_start = 1'b1;
                           state_in     = S_READ;
                        end
                     end
                  end
                  OP_TX_TICK: begin
                     if (status.tx_can_send) begin
                        cmd.tx_advance = 1'b1;
                        state_in       = S_READ;
                     end else begin
                        cmd.tx_stop = 1'b1;
                     end
                  end
                  OP_RX_BYTE: begin
                     cmd.rx_write = 1'b1;
                  end
                  OP_READ: begin
                     if (status.rx_empty) begin
                        state_in = S_EMPTY;
                     end else begin
                        cmd.rd_start = 1'b1;
                        state_in     = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.rd_is_rx) begin
                  cmd.out_kind = KIND_RX;
                  if (status.rd_last) begin
                     state_in = S_IDLE;
                  end else begin
                     // Fetch the following byte while this one is handed off.
                     cmd.rd_next = 1'b1;
                     cmd.mem_rd  = 1'b1;
                  end
               end else begin
                  cmd.out_kind = KIND_TX;
                  state_in     = S_IDLE;
               end
            end
         end
         S_EMPTY: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_EMPTY;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/utfb_datapath.sv
// ----------------------------------------------------------------------------
// UART terminated frame buffer datapath
// Transmit and receive stores, their counters and flags, and the result
// register.
// ----------------------------------------------------------------------------
module utfb_datapath
   import utfb_pkg::*;
#(
   parameter int BUF_DEPTH = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [BYTE_W-1:0] byte_in,
   input  logic              csr_we,
   input  logic [BYTE_W-1:0] csr_wdata,
   input  logic              out_ready,
   output status_type        status,
   output logic              out_valid,
   output logic [KIND_W-1:0] out_kind,
   output logic [BYTE_W-1:0] out_data,
   output logic              out_last,
   output logic [FLEN_W-1:0] out_flen,
   output logic              out_frame_ready,
   output logic              out_sending
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int CW = $clog2(BUF_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic [BYTE_W-1:0] tx_mem [BUF_DEPTH];
   logic [BYTE_W-1:0] rx_mem [BUF_DEPTH];

   logic [BYTE_W-1:0] end_char_ff;
   logic [CW-1:0]     tx_fill_ff, tx_fill_in;
   logic [CW-1:0]     tx_length_ff, tx_length_in;
   logic [CW-1:0]     tx_pos_ff, tx_pos_in;
   logic              tx_busy_ff, tx_busy_in;
   logic [AW-1:0]     tx_addr_ff, tx_addr_in;
   logic [CW-1:0]     rx_len_ff, rx_len_in;
   logic              rx_busy_ff, rx_busy_in;
   logic [CW-1:0]     rd_len_ff, rd_len_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic              rd_src_rx_ff, rd_src_rx_in;
   logic              out_valid_ff;
   logic [BYTE_W-1:0] tx_rd_data_ff;
   logic [BYTE_W-1:0] rx_rd_data_ff;

   logic [KIND_W-1:0] out_kind_ff;
   logic [BYTE_W-1:0] out_data_ff;
   logic              out_last_ff;
   logic [FLEN_W-1:0] out_flen_ff;
   logic              out_frame_ready_ff;
   logic              out_sending_ff;

   logic              tx_full;
   logic              tx_wr_en;
   logic              rx_full;
   logic              rx_wr_en;
   logic [AW-1:0]     rx_idx;
   logic [CW-1:0]     rd_ptr_inc;
   logic [BYTE_W-1:0] res_data;
   logic [FLEN_W-1:0] res_flen;

   assign tx_full    = (tx_fill_ff == DEPTH_C);
   assign tx_wr_en   = cmd.tx_write && !tx_full;
   assign rx_full    = (rx_len_ff == DEPTH_C);
   assign rx_wr_en   = cmd.rx_write && !rx_full;
   assign rx_idx     = rx_busy_ff ? rx_len_ff[AW-1:0] : '0;
   assign rd_ptr_inc = CW'(rd_ptr_ff) + ONE_C;

   always_comb begin
      tx_fill_in   = tx_fill_ff;
      tx_length_in = tx_length_ff;
      tx_pos_in    = tx_pos_ff;
      tx_busy_in   = tx_busy_ff;
      tx_addr_in   = tx_addr_ff;
      rx_len_in    = rx_len_ff;
      rx_busy_in   = rx_busy_ff;
      rd_len_in    = rd_len_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_src_rx_in = rd_src_rx_ff;

      if (tx_wr_en) begin
         tx_fill_in = tx_fill_ff + ONE_C;
      end
      if (cmd.tx_start) begin
         // A full store drops the final byte but still sends what it holds.
         tx_length_in = tx_fill_in;
         tx_fill_in   = '0;
         tx_pos_in    = ONE_C;
         tx_busy_in   = 1'b1;
         tx_addr_in   = '0;
         rd_src_rx_in = 1'b0;
      end
      if (cmd.tx_advance) begin
         tx_addr_in   = tx_pos_ff[AW-1:0];
         tx_pos_in    = tx_pos_ff + ONE_C;
         rd_src_rx_in = 1'b0;
      end
      if (cmd.tx_stop) begin
         tx_busy_in = 1'b0;
      end

      if (cmd.rx_write) begin
         if (rx_full) begin
            rx_len_in = '0;
         end else begin
            rx_len_in  = CW'(rx_idx) + ONE_C;
            rx_busy_in = (byte_in != end_char_ff);
         end
      end
      if (cmd.rd_start) begin
         rd_len_in    = rx_len_ff;
         rx_len_in    = '0;
         rd_ptr_in    = '0;
         rd_src_rx_in = 1'b1;
      end
      if (cmd.rd_next) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_char_ff  <= END_CHAR_RESET;
         tx_fill_ff   <= '0;
         tx_length_ff <= '0;
         tx_pos_ff    <= '0;
         tx_busy_ff   <= 1'b0;
         tx_addr_ff   <= '0;
         rx_len_ff    <= '0;
         rx_busy_ff   <= 1'b0;
         rd_len_ff    <= '0;
         rd_ptr_ff    <= '0;
         rd_src_rx_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            end_char_ff <= csr_wdata;
         end
         tx_fill_ff   <= tx_fill_in;
         tx_length_ff <= tx_length_in;
         tx_pos_ff    <= tx_pos_in;
         tx_busy_ff   <= tx_busy_in;
         tx_addr_ff   <= tx_addr_in;
         rx_len_ff    <= rx_len_in;
         rx_busy_ff   <= rx_busy_in;
         rd_len_ff    <= rd_len_in;
         rd_ptr_ff    <= rd_ptr_in;
         rd_src_rx_ff <= rd_src_rx_in;
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Stores: one write port each, registered read.
   always_ff @(posedge clock) begin
      if (tx_wr_en) begin
         tx_mem[tx_fill_ff[AW-1:0]] <= byte_in;
      end
      if (cmd.mem_rd) begin
         tx_rd_data_ff <= tx_mem[tx_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rx_wr_en) begin
         rx_mem[rx_idx] <= byte_in;
      end
      if (cmd.mem_rd) begin
         rx_rd_data_ff <= rx_mem[rd_ptr_in];
      end
   end

   always_comb begin
      case (cmd.out_kind)
         KIND_TX: begin
            res_data = tx_rd_data_ff;
            res_flen = FLEN_W'(rx_len_ff);
         end
         KIND_RX: begin
            res_data = rx_rd_data_ff;
            res_flen = FLEN_W'(rd_len_ff);
         end
         default: begin
            res_data = '0;
            res_flen = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_kind_ff        <= cmd.out_kind;
         out_data_ff        <= res_data;
         out_last_ff        <= (cmd.out_kind != KIND_RX) || (rd_ptr_inc == rd_len_ff);
         out_flen_ff        <= res_flen;
         out_frame_ready_ff <= (res_flen != '0) && !rx_busy_ff;
         out_sending_ff     <= tx_busy_ff;
      end
   end

   assign status.tx_busy     = tx_busy_ff;
   assign status.tx_can_send = (tx_pos_ff < tx_length_ff);
   assign status.rx_empty    = (rx_len_ff == '0);
   assign status.rd_is_rx    = rd_src_rx_ff;
   assign status.rd_last     = (rd_ptr_inc == rd_len_ff);
   assign status.out_free    = !out_valid_ff || out_ready;

   assign out_valid       = out_valid_ff;
   assign out_kind        = out_kind_ff;
   assign out_data        = out_data_ff;
   assign out_last        = out_last_ff;
   assign out_flen        = out_flen_ff;
   assign out_frame_ready = out_frame_ready_ff;
   assign out_sending     = out_sending_ff;

endmodule

FILE: rtl/uart_terminated_frame_buffer.sv
// ----------------------------------------------------------------------------
// UART terminated frame buffer
// Buffers a transmit frame and gathers a received frame closed by an end
// character, with status reported on every result.
// ----------------------------------------------------------------------------
// Usage: each request transaction carries an operation on req_tuser (load a
// transmit byte, transmit tick, received byte, read frame), a byte on
// req_tdata and, for loads, the final-byte mark on req_tlast. Loads, received
// bytes and ticks that end a send give no response. A load marked last, or a
// tick with bytes left, gives one response transaction carrying the next
// transmit byte, passed through the registered store read and the result
// register. A read gives one response per stored byte, through the same
// registers, one per cycle while rsp_tready stays high, or a single
// empty-status response if no bytes are stored. The block works on one
// request at a time; req_tready is high only while no request is in progress,
// so a request that gives a response frees the input in the cycle after its
// last response is loaded into the result register. When the receiver
// stalls, the result register holds its transaction and the run pauses
// without losing or repeating bytes. The end character is written through
// csr_we and csr_wdata; the user must do so only while the block is idle,
// which the block itself does not enforce.
// Reset clears all counters and flags, returns the end character to a line
// feed, and leaves the store contents as they were.
// ----------------------------------------------------------------------------
module uart_terminated_frame_buffer
   import utfb_pkg::*;
#(
   parameter int BUF_DEPTH = 64
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,   // end_char

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_in
   input  logic [1:0]  req_tuser,   // op
   input  logic        req_tlast,   // load_last

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] data_out, [14:8] frame_length, [15] frame_ready, [16] sending,
   // [23:17] zero
   output logic [23:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // run_last
);

   cmd_type           cmd;
   status_type        status;
   logic [KIND_W-1:0] out_kind;
   logic [BYTE_W-1:0] out_data;
   logic              out_last;
   logic [FLEN_W-1:0] out_flen;
   logic              out_frame_ready;
   logic              out_sending;

   // The controller decodes the operation and steps the read sequence.
   utfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_last  (req_tlast),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   // The datapath owns both stores, their counters and the result register.
   utfb_datapath #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .byte_in         (req_tdata),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .out_ready       (rsp_tready),
      .status          (status),
      .out_valid       (rsp_tvalid),
      .out_kind        (out_kind),
      .out_data        (out_data),
      .out_last        (out_last),
      .out_flen        (out_flen),
      .out_frame_ready (out_frame_ready),
      .out_sending     (out_sending)
   );

   // Pack the result fields, lowest field first, padded to whole bytes.
   assign rsp_tdata = {7'b0, out_sending, out_frame_ready, out_flen, out_data};
   assign rsp_tuser = out_kind;
   assign rsp_tlast = out_last;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART terminated frame buffer testbench
// Drives transmit loads, transmit ticks, received bytes and frame reads into
// the buffer and keeps a cycle-free shadow of its transmit and receive state.
// From that shadow it predicts every response transaction. A separate process
// compares each response with the oldest prediction, field by field. Both
// sides idle at random, the end character is changed between phases, and one
// phase holds the response side off long enough for the request side to stall.
// ----------------------------------------------------------------------------
module tb;
   import utfb_pkg::*;

   localparam int DEPTH        = 64;
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
   localparam int SETTLE_LIMIT = 6000;     // bound on waiting for a drain
   localparam int TAIL_CYCLES  = 10;       // tail wait after a drain
   localparam int TIMEOUT_NS   = 20_000_000;

   // One expected response transaction, in the order of its fields.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic              run_last;
      logic [FLEN_W-1:0] frame_length;
      logic              frame_ready;
      logic              sending;
   } line_result_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // byte_in
   logic [1:0]  req_tuser;    // op
   logic        req_tlast;    // load_last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // data_out, frame_length, frame_ready, sending, zero
   logic [1:0]  rsp_tuser;    // kind
   logic        rsp_tlast;    // run_last

   uart_terminated_frame_buffer #(
      .BUF_DEPTH (DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Shadow of the buffer: the end character, the transmit frame being loaded
   // or sent, and the receive frame being gathered.
   logic [7:0]   end_char_shadow;
   logic [7:0]   tx_bytes [DEPTH];
   int           tx_count;      // bytes loaded into the next transmit frame
   int           tx_total;      // length of the frame on the line
   int           tx_next;       // index of the next byte to put on the line
   bit           tx_active;
   logic [7:0]   rx_bytes [DEPTH];
   int           rx_count;
   bit           rx_open;       // a frame is arriving, no end character yet

   line_result_type awaited_results [$];
   line_result_type want;
   int           errors;
   int           items_applied;  // transactions that changed the buffer state

   // Handshake between the main sequence and the receiver for the long hold.
   bit           hold_request;
   bit           hold_active;

   // The period is 12 ns.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The run is cut off here if the stimulus or the drain never completes.
   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   // Queues one expected response; the status fields follow the shadow state
   // as it stands after the operation's own updates.
   function automatic void expect_result(input logic [KIND_W-1:0] kind,
                                         input logic [BYTE_W-1:0] data,
                                         input logic run_last, input int frame_len);
      line_result_type r;
      r.kind         = kind;
      r.data         = data;
      r.run_last     = run_last;
      r.frame_length = frame_len[FLEN_W-1:0];
      r.frame_ready  = (frame_len != 0) && !rx_open;
      r.sending      = tx_active;
      awaited_results.push_back(r);
   endfunction

   // Applies one accepted request to the shadow and queues what it causes.
   // Returns zero for requests that the buffer simply ignores.
   function automatic bit model_buffer_op(input logic [OP_W-1:0] op,
                                          input logic [7:0] value,
                                          input logic mark_last);
      int n;
      int i;
      bit effective;
      effective = 1'b1;
      case (op)
         OP_TX_LOAD: begin
            if (tx_active) begin
               effective = 1'b0;
            end else begin
               // A full store drops the byte, but a last mark still starts
               // the send with the bytes already held.
               if (tx_count < DEPTH) begin
                  tx_bytes[tx_count[IDX_W-1:0]] = value;
                  tx_count++;
               end
               if (mark_last) begin
                  tx_total  = tx_count;
                  tx_count  = 0;
                  tx_next   = 1;
                  tx_active = 1'b1;
                  expect_result(KIND_TX, tx_bytes[0], 1'b1, rx_count);
               end
            end
         end
         OP_TX_TICK: begin
            if (tx_next >= tx_total) begin
               // Frame spent: the busy flag drops with no response.
               effective = tx_active;
               tx_active = 1'b0;
            end else begin
               expect_result(KIND_TX, tx_bytes[tx_next[IDX_W-1:0]], 1'b1, rx_count);
               tx_next++;
            end
         end
         OP_RX_BYTE: begin
            if (rx_count >= DEPTH) begin
               // Overflow throws the frame away and leaves the busy flag.
               rx_count = 0;
            end else begin
               if (!rx_open)
                  rx_count = 0;
               rx_bytes[rx_count[IDX_W-1:0]] = value;
               rx_count++;
               rx_open = (value != end_char_shadow);
            end
         end
         default: begin
            n = rx_count;
            if (n == 0) begin
               expect_result(KIND_EMPTY, 8'h00, 1'b1, 0);
            end else begin
               for (i = 0; i < n; i++)
                  expect_result(KIND_RX, rx_bytes[i[IDX_W-1:0]], i == n - 1, n);
            end
            rx_count = 0;
         end
      endcase
      return effective;
   endfunction

   function automatic logic [7:0] non_end_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == end_char_shadow)
         b = b ^ 8'h01;
      return b;
   endfunction

   // Offers one request transaction, waits for its acceptance, predicts its
   // responses and then leaves a random gap. With no gap, tvalid stays high
   // so that the next call simply replaces the fields.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] value,
                            input logic mark_last);
      int pick;
      int gap;
      req_tuser  <= op;
      req_tdata  <= value;
      req_tlast  <= mark_last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (model_buffer_op(op, value, mark_last))
         items_applied++;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         gap = 0;
      else if (pick < 93)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering requests, waits for every predicted response, then lets
   // the block finish any request that gives no response.
   task automatic settle();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (awaited_results.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // The end character may only change while the block is idle.
   task automatic set_end_char(input logic [7:0] value);
      settle();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      end_char_shadow = value;
   endtask

   // Transmit side from reset: idle tick, two-byte send, a load refused while
   // sending, the tick that ends a send, and a single-byte frame.
   task automatic test_transmit_path();
      send_item(OP_TX_TICK, 8'h00, 1'b1);
      send_item(OP_TX_LOAD, 8'h00, 1'b0);
      send_item(OP_TX_LOAD, 8'hFF, 1'b1);
      send_item(OP_TX_LOAD, 8'h55, 1'b1);
      send_item(OP_TX_TICK, 8'hFF, 1'b0);
      send_item(OP_TX_TICK, 8'h00, 1'b0);
      send_item(OP_TX_LOAD, 8'hA5, 1'b1);
      send_item(OP_TX_TICK, 8'h5A, 1'b1);
   endtask

   // Receive side with the reset end character: empty read, closed frame,
   // partial frame read while still arriving, and a transmit response that
   // reports a waiting receive frame.
   task automatic test_receive_path();
      send_item(OP_READ, 8'h00, 1'b0);
      send_item(OP_RX_BYTE, 8'hFF, 1'b0);
      send_item(OP_RX_BYTE, 8'h00, 1'b1);
      send_item(OP_RX_BYTE, END_CHAR_RESET, 1'b0);
      send_item(OP_READ, 8'hFF, 1'b1);
      send_item(OP_RX_BYTE, 8'h41, 1'b0);
      send_item(OP_READ, 8'h00, 1'b0);
      send_item(OP_RX_BYTE, END_CHAR_RESET, 1'b1);
      send_item(OP_TX_LOAD, 8'h3C, 1'b1);
      send_item(OP_TX_TICK, 8'h00, 1'b0);
      send_item(OP_READ, 8'h00, 1'b1);
      send_item(OP_READ, 8'h7F, 1'b0);
   endtask

   // Both stores at their limits: a transmit frame offered two bytes too many,
   // the longest read run, and a receive frame that overflows.
   task automatic test_buffer_limits();
      int i;
      for (i = 1; i <= DEPTH + 2; i++)
         send_item(OP_TX_LOAD, 8'($urandom_range(0, 255)), i == DEPTH + 2);
      for (i = 0; i <= DEPTH; i++)
         send_item(OP_TX_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      for (i = 1; i <= DEPTH; i++)
         send_item(OP_RX_BYTE, (i == DEPTH) ? end_char_shadow : non_end_byte(), 1'b0);
      send_item(OP_READ, 8'h00, 1'b0);
      for (i = 1; i <= DEPTH + 1; i++)
         send_item(OP_RX_BYTE, non_end_byte(), 1'b1);
      send_item(OP_RX_BYTE, end_char_shadow, 1'b0);
      send_item(OP_READ, 8'h00, 1'b0);
   endtask

   // Holds the response side off for a long stretch while a long read and a
   // transmit frame are offered, so the block backs up and stalls requests.
   task automatic test_receiver_hold();
      int i;
      hold_request = 1'b1;
      while (!hold_active) @(posedge clock);
      for (i = 1; i <= 20; i++)
         send_item(OP_RX_BYTE, non_end_byte(), 1'($urandom_range(0, 1)));
      send_item(OP_RX_BYTE, end_char_shadow, 1'b0);
      send_item(OP_READ, 8'h00, 1'b0);
      for (i = 1; i <= 5; i++)
         send_item(OP_TX_LOAD, 8'($urandom_range(0, 255)), i == 5);
      for (i = 0; i <= 5; i++)
         send_item(OP_TX_TICK, 8'h00, 1'b0);
      send_item(OP_READ, 8'h00, 1'b0);
   endtask

   // Mostly well-formed transmit and receive frames with random content and
   // mostly small sizes, mixed with reads and with random noise requests.
   task automatic random_traffic(input int amount);
      int goal;
      int pick;
      int len;
      int i;
      bit closed;
      goal = items_applied + amount;
      while (items_applied < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, DEPTH + 6)
                                              : $urandom_range(1, 8);
            for (i = 1; i <= len; i++)
               send_item(OP_TX_LOAD, 8'($urandom_range(0, 255)), i == len);
            for (i = 0; i <= len; i++) begin
               // Receive bytes and refused loads may land between ticks.
               if ($urandom_range(0, 9) == 0)
                  send_item(OP_RX_BYTE, non_end_byte(), 1'($urandom_range(0, 1)));
               else if ($urandom_range(0, 19) == 0)
                  send_item(OP_TX_LOAD, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
               send_item(OP_TX_TICK, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            end
         end else if (pick < 62) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, DEPTH + 2)
                                              : $urandom_range(1, 8);
            closed = ($urandom_range(0, 9) < 8);
            for (i = 1; i <= len; i++)
               send_item(OP_RX_BYTE, (i == len && closed) ? end_char_shadow
                                                          : non_end_byte(),
                         1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) < 7)
               send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (pick < 75) begin
            send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++)
               send_item(OP_W'($urandom_range(OP_TX_LOAD, OP_READ)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Response checker: every accepted response transaction is matched with
   // the oldest prediction. Values are sampled as they stood before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected response: kind %0d data %0h", rsp_tuser, rsp_tdata[7:0]);
            errors++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[7:0] !== want.data) begin
               $error("data_out: expected %0h, got %0h", want.data, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tlast !== want.run_last) begin
               $error("run_last: expected %0d, got %0d", want.run_last, rsp_tlast);
               errors++;
            end
            if (rsp_tdata[14:8] !== want.frame_length) begin
               $error("frame_length: expected %0d, got %0d", want.frame_length,
                      rsp_tdata[14:8]);
               errors++;
            end
            if (rsp_tdata[15] !== want.frame_ready) begin
               $error("frame_ready: expected %0d, got %0d", want.frame_ready,
                      rsp_tdata[15]);
               errors++;
            end
            if (rsp_tdata[16] !== want.sending) begin
               $error("sending: expected %0d, got %0d", want.sending, rsp_tdata[16]);
               errors++;
            end
            if (rsp_tdata[23:17] !== 7'd0) begin
               $error("padding: expected 0, got %0h", rsp_tdata[23:17]);
               errors++;
            end
         end
      end
   end

   // Receiver: runs of ready, short and long stalls, and long stretches with
   // no stall at all. On request it holds off for a counted long stretch.
   initial begin
      int pick;
      int span;
      logic level;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            hold_active  = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               level = 1'b1;
               span  = $urandom_range(1, 12);
            end else if (pick < 55) begin
               level = 1'b1;
               span  = $urandom_range(40, 120);
            end else if (pick < 92) begin
               level = 1'b0;
               span  = $urandom_range(1, 3);
            end else begin
               level = 1'b0;
               span  = $urandom_range(10, 40);
            end
            rsp_tready <= level;
            repeat (span) @(posedge clock);
         end
      end
   end

   // Main sequence: reset, directed checks with the reset end character, then
   // random phases under different end characters, extremes included.
   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = END_CHAR_RESET;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = OP_TX_LOAD;
      req_tlast  = 1'b0;

      end_char_shadow = END_CHAR_RESET;
      tx_count        = 0;
      tx_total        = 0;
      tx_next         = 0;
      tx_active       = 1'b0;
      rx_count        = 0;
      rx_open         = 1'b0;
      errors          = 0;
      items_applied   = 0;
      hold_request    = 1'b0;
      hold_active     = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_transmit_path();
      test_receive_path();

      set_end_char(8'h00);
      test_buffer_limits();
      random_traffic(10);

      set_end_char(8'hFF);
      random_traffic(10);

      set_end_char(8'($urandom_range(1, 254)));
      test_receiver_hold();
      random_traffic(10);

      settle();
      if (awaited_results.size() != 0) begin
         $error("%0d expected responses never arrived", awaited_results.size());
         errors++;
      end
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
rtl/utfb_pkg.sv
rtl/utfb_ctrl.sv
rtl/utfb_datapath.sv
rtl/uart_terminated_frame_buffer.sv
verif/tb.sv
